// ----- design/sfla_pkg.sv -----
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared types and constants for the slab free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

	localparam int NUM_BLOCKS_DEF = 1024;

	localparam logic [31:0] BLOCK_SIZE_RST  = 32'd4096;
	localparam logic [10:0] BLOCK_COUNT_RST = 11'd1024;

	// register indexes on the configuration port
	localparam logic REG_BLOCK_SIZE  = 1'b0;
	localparam logic REG_BLOCK_COUNT = 1'b1;

	// request kinds
	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LARGE = 2'd1;
	localparam logic [1:0] ST_MISALIGN  = 2'd2;
	localparam logic [1:0] ST_EXHAUSTED = 2'd3;

	typedef struct packed {
		logic        req_type;
		logic [31:0] request_size;
		logic [4:0]  align_shift;
		logic [9:0]  free_index;
	} sfla_req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [9:0]  block_index;
		logic [41:0] block_offset;
	} sfla_rsp_t;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} sfla_state_t;

	// controller to datapath
	typedef struct packed {
		logic take;
		logic commit;
	} sfla_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
	} sfla_sts_t;

endpackage

// ----- design/sfla_ram.sv -----
// ----------------------------------------------------------------------------
// sfla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/sfla_ctrl.sv -----
// ----------------------------------------------------------------------------
// sfla_ctrl
// Controller: takes one request, then commits it once the result slot frees.
// ----------------------------------------------------------------------------
module sfla_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfla_pkg::sfla_sts_t sts,
	output sfla_pkg::sfla_cmd_t cmd
);
	import sfla_pkg::*;

	sfla_state_t state_q;
	sfla_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.take   = 1'b0;
		cmd.commit = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			S_EXEC: begin
				cmd.commit = sts.slot_free;
			end
			default: ;
		endcase
	end

endmodule

// ----- design/sfla_dp.sv -----
// ----------------------------------------------------------------------------
// sfla_dp
// Datapath: free-list head, bump index, link store and result register.
// ----------------------------------------------------------------------------
module sfla_dp #(
	parameter int NUM_BLOCKS = sfla_pkg::NUM_BLOCKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sfla_pkg::sfla_cmd_t cmd,
	output sfla_pkg::sfla_sts_t sts,
	input  sfla_pkg::sfla_req_t in_data,
	input  logic [31:0]         block_size,
	input  logic [10:0]         block_count,
	output logic                out_valid,
	input  logic                out_ready,
	output sfla_pkg::sfla_rsp_t out_data
);
	import sfla_pkg::*;

	localparam int IW = $clog2(NUM_BLOCKS);
	localparam int LW = IW + 1;
	localparam int CW = (IW + 1 > 11) ? IW + 1 : 11;
	localparam int FW = (IW + 1 > 10) ? IW + 1 : 10;
	localparam int PW = IW + 32;

	sfla_req_t   req_q;
	logic        head_valid_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] bump_q;
	logic        link0_wr_q;
	logic        out_valid_q;
	sfla_rsp_t   out_q;

	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [LW-1:0] ram_wdata;
	logic [LW-1:0] ram_rdata;

	logic          is_free;
	logic          free_ok;
	logic          too_big;
	logic          misal;
	logic          alloc;
	logic          grant;
	logic [LW-1:0] link;
	logic          pop_valid;
	logic [IW-1:0] pop_idx;
	logic [CW-1:0] eff_count;
	logic [IW-1:0] bump_nx;
	logic          bump_ok;
	logic [31:0]   align_mask;
	logic [PW-1:0] prod;
	logic [1:0]    status;

	sfla_ram #(
		.WIDTH(LW),
		.DEPTH(NUM_BLOCKS)
	) u_link (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		is_free    = (req_q.req_type == REQ_FREE);
		free_ok    = (FW'(req_q.free_index) < FW'(NUM_BLOCKS));
		too_big    = (req_q.request_size > block_size);
		align_mask = (32'd1 << req_q.align_shift) - 32'd1;
		misal      = ((block_size & align_mask) != 32'd0);
		alloc      = !is_free && !too_big && !misal;
		grant      = alloc && head_valid_q;

		// entry zero reads as null until something is written there
		link = (head_q == '0 && !link0_wr_q) ? '0 : ram_rdata;

		pop_valid = head_valid_q ? link[IW] : 1'b0;
		pop_idx   = head_valid_q ? link[IW-1:0] : head_q;

		eff_count = (CW'(block_count) < CW'(NUM_BLOCKS)) ? CW'(block_count)
			: CW'(NUM_BLOCKS);
		bump_nx   = bump_q + IW'(1);
		bump_ok   = !pop_valid && ((CW'(bump_q) + CW'(1)) < eff_count);

		ram_we    = cmd.commit && ((is_free && free_ok) || (alloc && bump_ok));
		ram_waddr = is_free ? IW'(req_q.free_index) : bump_nx;
		ram_wdata = (is_free && head_valid_q) ? {1'b1, head_q} : '0;

		if (is_free) begin
			status = ST_OK;
		end else if (too_big) begin
			status = ST_TOO_LARGE;
		end else if (misal) begin
			status = ST_MISALIGN;
		end else if (head_valid_q) begin
			status = ST_OK;
		end else begin
			status = ST_EXHAUSTED;
		end

		prod = PW'(head_q) * PW'(block_size);

		sts.slot_free = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			req_q <= in_data;
		end
		if (cmd.commit) begin
			out_q.status       <= status;
			out_q.block_index  <= grant ? 10'(head_q) : 10'd0;
			out_q.block_offset <= grant ? 42'(prod) : 42'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b1;
			head_q       <= '0;
			bump_q       <= '0;
			link0_wr_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
				if (is_free && free_ok) begin
					head_valid_q <= 1'b1;
					head_q       <= IW'(req_q.free_index);
				end else if (alloc) begin
					head_valid_q <= pop_valid || bump_ok;
					head_q       <= bump_ok ? bump_nx : pop_idx;
					if (bump_ok) begin
						bump_q <= bump_nx;
					end
				end
				if (ram_we && ram_waddr == '0) begin
					link0_wr_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- design/slab_free_list_allocator_top.sv -----
// ----------------------------------------------------------------------------
// slab_free_list_allocator_top
// Fixed-size block allocator over a slab with a linked free list.
// ----------------------------------------------------------------------------
// A request is taken in the idle state; in the exec state the head's link
// comes out of the synchronous link store and the result is loaded into
// the output register. The next request is taken right after, while the
// previous result may still wait at the output; a result that is not taken
// holds the next request in exec. No clearing pass follows reset: block
// zero's link reads as null until it is first written. Configuration is
// written through the APB port at 0x0 (block_size) and 0x4 (block_count).
module slab_free_list_allocator_top #(
	parameter int NUM_BLOCKS = sfla_pkg::NUM_BLOCKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sfla_pkg::sfla_req_t in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output sfla_pkg::sfla_rsp_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import sfla_pkg::*;

	logic [31:0] block_size_q;
	logic [10:0] block_count_q;
	sfla_cmd_t   cmd;
	sfla_sts_t   sts;
	logic        reg_sel;

	assign reg_sel = paddr[2];
	assign pready  = 1'b1;
	assign prdata  = (reg_sel == REG_BLOCK_COUNT) ? 32'(block_count_q) : block_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_size_q  <= BLOCK_SIZE_RST;
			block_count_q <= BLOCK_COUNT_RST;
		end else if (psel && penable && pwrite && pready) begin
			if (reg_sel == REG_BLOCK_SIZE) begin
				block_size_q <= pwdata;
			end else begin
				block_count_q <= pwdata[10:0];
			end
		end
	end

	sfla_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	sfla_dp #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.in_data    (in_data),
		.block_size (block_size_q),
		.block_count(block_count_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

// ----- design/sfla_checker.sv -----
// ----------------------------------------------------------------------------
// sfla_props
// Port-level checks for the slab free-list allocator, bound to the top level.
// ----------------------------------------------------------------------------
module sfla_props (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input sfla_pkg::sfla_rsp_t out_data,
	input logic                pready
);
	import sfla_pkg::*;

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one request at a time: no transfer in the cycle after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken back to back");

	// a failed allocate grants nothing
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
			out_data.block_index == 10'd0 && out_data.block_offset == 42'd0)
		else $error("failed result carries a block");

	// the request side opens again once the result slot drains
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready && (!out_valid || out_ready) |=> in_ready)
		else $error("request side stuck");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind slab_free_list_allocator_top sfla_props u_sfla_props (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data),
	.pready   (pready)
);

// ----- sim/sfla_checker.sv -----
// ----------------------------------------------------------------------------
// sfla_checker
// Watches the request, result and register ports of the slab allocator. It
// keeps its own copy of the free list, the bump index and the two registers,
// works out the result of every request transfer and compares each result
// transfer, field by field, with the oldest result still due.
// ----------------------------------------------------------------------------
module sfla_checker #(
	parameter int NUM_BLOCKS = sfla_pkg::NUM_BLOCKS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  sfla_pkg::sfla_req_t in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  sfla_pkg::sfla_rsp_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	input  logic                pready,
	output int                  errors,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import sfla_pkg::*;

	logic [31:0] slab_size;
	logic [10:0] slab_count;
	logic        hd_valid;
	logic [9:0]  hd_idx;
	logic [9:0]  bump_at;
	logic [10:0] link_mem [NUM_BLOCKS];
	sfla_rsp_t   due_rsp [$];
	int          miss = 0;

	// Apply one request to the shadow free list and return its result.
	function automatic sfla_rsp_t serve_request(sfla_req_t rq);
		sfla_rsp_t   r;
		logic [10:0] lk;
		logic [31:0] low_bits;
		logic        granted;
		logic [9:0]  got;
		int          eff;
		r = '0;
		if (rq.req_type == REQ_FREE) begin
			if (int'(rq.free_index) < NUM_BLOCKS) begin
				link_mem[rq.free_index] = hd_valid ? {1'b1, hd_idx} : 11'd0;
				hd_valid = 1'b1;
				hd_idx = rq.free_index;
			end
			r.status = ST_OK;
			return r;
		end
		if (rq.request_size > slab_size) begin
			r.status = ST_TOO_LARGE;
			return r;
		end
		low_bits = ~(32'hFFFF_FFFF << rq.align_shift);
		if ((slab_size & low_bits) != 32'd0) begin
			r.status = ST_MISALIGN;
			return r;
		end
		granted = hd_valid;
		got = hd_idx;
		if (hd_valid) begin
			lk = link_mem[hd_idx];
			hd_valid = lk[10];
			hd_idx = lk[9:0];
		end
		// list ran dry: carve the next untouched block, if the slab has one
		eff = (int'(slab_count) < NUM_BLOCKS) ? int'(slab_count) : NUM_BLOCKS;
		if (!hd_valid && int'(bump_at) + 1 < eff) begin
			bump_at = bump_at + 10'd1;
			hd_valid = 1'b1;
			hd_idx = bump_at;
			link_mem[bump_at] = 11'd0;
		end
		if (granted) begin
			r.status = ST_OK;
			r.block_index = got;
			r.block_offset = {32'd0, got} * {10'd0, slab_size};
		end else begin
			r.status = ST_EXHAUSTED;
		end
		return r;
	endfunction

	function automatic void check_field(string name, logic [63:0] want_v, logic [63:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, actual %0d", name, want_v, got_v);
			miss++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sfla_rsp_t want;
		if (!arst_n) begin
			slab_size = BLOCK_SIZE_RST;
			slab_count = BLOCK_COUNT_RST;
			hd_valid = 1'b1;
			hd_idx = '0;
			bump_at = '0;
			foreach (link_mem[j]) link_mem[j] = '0;
			due_rsp.delete();
			pending <= 0;
		end else begin
			// results first: a request taken at this edge cannot answer at it
			if (out_valid && out_ready) begin
				if (due_rsp.size() == 0) begin
					$error("result transfer with none due: status %0d index %0d offset %0d",
						out_data.status, out_data.block_index, out_data.block_offset);
					miss++;
				end else begin
					want = due_rsp.pop_front();
					check_field("status", 64'(want.status), 64'(out_data.status));
					check_field("block_index", 64'(want.block_index),
						64'(out_data.block_index));
					check_field("block_offset", 64'(want.block_offset),
						64'(out_data.block_offset));
				end
			end
			if (in_valid && in_ready)
				due_rsp.push_back(serve_request(in_data));
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_BLOCK_SIZE)
					slab_size = pwdata;
				else
					slab_count = pwdata[10:0];
			end
			pending <= due_rsp.size();
		end
		errors <= miss;
	end

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives the slab allocator with a directed opening and then phases of
// random allocate and free traffic under several slab settings and idle
// patterns, with frees mostly returning blocks that were granted. A separate
// checker tracks the free list and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import sfla_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	sfla_req_t   in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	sfla_rsp_t   out_data;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	int          errors;
	int          pending;

	int          tx_idle = 0;
	int          rx_idle = 0;
	int          hold_reqs = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          quiet = 0;
	logic [31:0] cur_size = BLOCK_SIZE_RST;
	logic [10:0] cur_count = BLOCK_COUNT_RST;

	// blocks granted and not yet given back, for well-formed frees
	logic        in_hit = 1'b0;
	logic        out_hit = 1'b0;
	sfla_req_t   in_seen = '0;
	sfla_rsp_t   out_seen = '0;
	logic        req_kinds [$];
	logic [9:0]  owned_blocks [$];

	always #10 clk = ~clk;

	slab_free_list_allocator_top uut (.*);

	sfla_checker chk (.*);

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			hold_left <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99, 0) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// latch transfers at the edge, update the owned list at the falling edge
	always @(posedge clk) begin
		in_hit <= in_valid && in_ready;
		in_seen <= in_data;
		out_hit <= out_valid && out_ready;
		out_seen <= out_data;
	end

	always @(negedge clk) begin
		int pos;
		pos = -1;
		if (out_hit && req_kinds.size() != 0) begin
			if (req_kinds.pop_front() == REQ_ALLOC && out_seen.status == ST_OK)
				owned_blocks.push_back(out_seen.block_index);
		end
		if (in_hit) begin
			req_kinds.push_back(in_seen.req_type);
			if (in_seen.req_type == REQ_FREE) begin
				foreach (owned_blocks[j])
					if (owned_blocks[j] == in_seen.free_index) pos = j;
				if (pos >= 0) owned_blocks.delete(pos);
			end
		end
	end

	function automatic sfla_req_t alloc_req(logic [31:0] size, logic [4:0] shift);
		sfla_req_t rq;
		rq = '0;
		rq.req_type = REQ_ALLOC;
		rq.request_size = size;
		rq.align_shift = shift;
		return rq;
	endfunction

	function automatic sfla_req_t free_req(logic [9:0] idx);
		sfla_req_t rq;
		rq = '0;
		rq.req_type = REQ_FREE;
		rq.free_index = idx;
		return rq;
	endfunction

	task automatic send(input sfla_req_t rq);
		in_data <= rq;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic sender_gap();
		int n;
		n = 0;
		while ($urandom_range(99, 0) < tx_idle) n++;
		if (n != 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// drop valid and wait until every result due has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_slab(input logic [31:0] sz, input logic [10:0] cnt);
		cfg_write(REG_BLOCK_SIZE, sz);
		cfg_write(REG_BLOCK_COUNT, {21'd0, cnt});
		cur_size = sz;
		cur_count = cnt;
	endtask

	task automatic set_idle(input int tx, input int rx);
		tx_idle = tx;
		rx_idle <= rx;
	endtask

	task automatic run_phase(input int n, input int alloc_pct, input int noise_pct);
		sfla_req_t   rq;
		int          tz;
		int          pick;
		logic [31:0] cap;
		logic [9:0]  freed_last;
		logic        freed_prev;
		tz = 0;
		while (tz < 31 && !cur_size[tz]) tz++;
		cap = (cur_size < 32'd64) ? cur_size : 32'd64;
		freed_prev = 1'b0;
		freed_last = '0;
		for (int k = 0; k < n; k++) begin
			if (k != 0) sender_gap();
			rq.req_type = REQ_ALLOC;
			rq.request_size = $urandom();
			rq.align_shift = 5'($urandom_range(31, 0));
			rq.free_index = 10'($urandom_range(1023, 0));
			if ($urandom_range(99, 0) < noise_pct) begin
				// stray free of any block, owned or not
				rq.req_type = REQ_FREE;
			end else if ($urandom_range(99, 0) >= alloc_pct && owned_blocks.size() != 0) begin
				pick = $urandom_range(owned_blocks.size() - 1, 0);
				// the free just taken is not off the owned list yet
				if (!(freed_prev && owned_blocks[pick] == freed_last)) begin
					rq.req_type = REQ_FREE;
					rq.free_index = owned_blocks[pick];
				end
			end
			if (rq.req_type == REQ_ALLOC) begin
				if ($urandom_range(99, 0) < 85) begin
					case ($urandom_range(2, 0))
						0: rq.request_size = cur_size;
						1: rq.request_size = $urandom_range(cur_size, 0);
						default: rq.request_size = $urandom_range(cap, 0);
					endcase
					rq.align_shift = 5'($urandom_range(tz, 0));
				end else if (tz < 31 &&
					(cur_size == 32'hFFFF_FFFF || $urandom_range(1, 0) == 0)) begin
					rq.request_size = $urandom_range(cur_size, 0);
					rq.align_shift = 5'($urandom_range(31, tz + 1));
				end else begin
					rq.request_size = $urandom_range(32'hFFFF_FFFF, cur_size + 32'd1);
				end
			end
			freed_prev = (rq.req_type == REQ_FREE);
			freed_last = rq.free_index;
			send(rq);
		end
		drain();
	endtask

	initial begin
		sfla_req_t opening [$];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idle(23, 81);
		opening = '{
			alloc_req(32'd0, 5'd0),
			alloc_req(32'd4096, 5'd12),
			alloc_req(32'd4097, 5'd0),
			alloc_req(32'hFFFF_FFFF, 5'd31),
			alloc_req(32'd1, 5'd13),
			alloc_req(32'd0, 5'd31),
			free_req(10'd1023),
			free_req(10'd0),
			alloc_req(32'd100, 5'd3),
			alloc_req(32'd4096, 5'd0),
			alloc_req(32'd1, 5'd1),
			free_req(10'd1),
			free_req(10'd2),
			alloc_req(32'd4096, 5'd12),
			alloc_req(32'd2048, 5'd11),
			alloc_req(32'd4095, 5'd12)
		};
		foreach (opening[j]) begin
			if (j != 0) sender_gap();
			send(opening[j]);
		end
		drain();

		set_slab(32'd4096, 11'd16);
		run_phase(150, 80, 0);
		set_slab(32'd1, 11'd1);
		run_phase(150, 65, 0);
		set_slab(32'hFFFF_FFFF, 11'd1024);
		run_phase(300, 70, 0);

		set_idle(81, 23);
		set_slab(32'h8000_0000, 11'd1024);
		hold_reqs <= hold_reqs + 1;
		run_phase(300, 75, 0);
		set_slab((32'($urandom()) | 32'd1) << $urandom_range(20, 0),
			11'($urandom_range(1024, 1)));
		run_phase(250, 50, 0);

		set_idle(0, 0);
		set_slab(BLOCK_SIZE_RST, BLOCK_COUNT_RST);
		hold_reqs <= hold_reqs + 1;
		run_phase(300, 80, 0);
		set_slab((32'($urandom()) | 32'd1) << $urandom_range(12, 0), 11'd8);
		run_phase(80, 50, 20);

		repeat (8) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
